// ===== src/dpb_pkg.sv =====
// Shared types, widths and constants for the depth pixel back-projection block.
// Used by every module under src; depends on nothing.
package dpb_pkg;

    // Fixed field widths
    localparam int DEPTH_W  = 16;
    localparam int SCALE_W  = 16;
    localparam int FOCAL_W  = 20;
    localparam int CENTER_W = 20;
    localparam int PIXEL_W  = 12;
    localparam int COLOUR_W = 8;
    localparam int Q_W      = 32;

    // Design constants
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;

    // Derived widths
    localparam int POS_W   = COORD_BITS + 8;
    localparam int MAG_W   = (POS_W > CENTER_W) ? POS_W : CENTER_W;
    localparam int A_W     = MAG_W + DEPTH_W;
    localparam int D_W     = SCALE_W + FOCAL_W;
    localparam int CMP_W   = A_W + D_W;
    localparam int SHIFT   = Q_W - FRAC_BITS;
    localparam int DIV_LAT = Q_W + 1;

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = ADDR_W - 2;

    localparam logic [IDX_W-1:0] REG_DEPTH_SCALE = 3'd0;
    localparam logic [IDX_W-1:0] REG_FOCAL_X     = 3'd1;
    localparam logic [IDX_W-1:0] REG_FOCAL_Y     = 3'd2;
    localparam logic [IDX_W-1:0] REG_CENTER_X    = 3'd3;
    localparam logic [IDX_W-1:0] REG_CENTER_Y    = 3'd4;

    localparam logic [SCALE_W-1:0]  RST_DEPTH_SCALE = 16'd1000;
    localparam logic [FOCAL_W-1:0]  RST_FOCAL_X     = 20'd134400;
    localparam logic [FOCAL_W-1:0]  RST_FOCAL_Y     = 20'd134400;
    localparam logic [CENTER_W-1:0] RST_CENTER_X    = 20'd81792;
    localparam logic [CENTER_W-1:0] RST_CENTER_Y    = 20'd61312;

    localparam logic [Q_W-1:0] CAP_POS = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] CAP_NEG = 32'h8000_0000;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic [SCALE_W-1:0]  depth_scale;
        logic [FOCAL_W-1:0]  focal_x;
        logic [FOCAL_W-1:0]  focal_y;
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
    } cfg_t;

    typedef struct packed {
        logic                neg_x;
        logic                neg_y;
        logic [COLOUR_W-1:0] blue;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] red;
    } side_t;

endpackage

// ===== src/dpb_cfg.sv =====
// APB-style register file holding the camera intrinsics and depth scale.
// Depends on dpb_pkg.
module dpb_cfg import dpb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic [IDX_W-1:0] idx;

    assign idx    = paddr[ADDR_W-1:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_DEPTH_SCALE: cfg_next.depth_scale = pwdata[SCALE_W-1:0];
                REG_FOCAL_X:     cfg_next.focal_x     = pwdata[FOCAL_W-1:0];
                REG_FOCAL_Y:     cfg_next.focal_y     = pwdata[FOCAL_W-1:0];
                REG_CENTER_X:    cfg_next.center_x    = pwdata[CENTER_W-1:0];
                REG_CENTER_Y:    cfg_next.center_y    = pwdata[CENTER_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_DEPTH_SCALE: prdata = DATA_W'(cfg_reg.depth_scale);
            REG_FOCAL_X:     prdata = DATA_W'(cfg_reg.focal_x);
            REG_FOCAL_Y:     prdata = DATA_W'(cfg_reg.focal_y);
            REG_CENTER_X:    prdata = DATA_W'(cfg_reg.center_x);
            REG_CENTER_Y:    prdata = DATA_W'(cfg_reg.center_y);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depth_scale <= RST_DEPTH_SCALE;
            cfg_reg.focal_x     <= RST_FOCAL_X;
            cfg_reg.focal_y     <= RST_FOCAL_Y;
            cfg_reg.center_x    <= RST_CENTER_X;
            cfg_reg.center_y    <= RST_CENTER_Y;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/dpb_prep.sv =====
// Front end: pixel offset from the principal point, then numerator and
// divisor products for the three divisions. Two register stages. Uses dpb_pkg.
module dpb_prep import dpb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [PIXEL_W-1:0]  pixel_column,
    input  logic [PIXEL_W-1:0]  pixel_row,
    input  logic [DEPTH_W-1:0]  pixel_depth,
    input  logic [COLOUR_W-1:0] in_blue,
    input  logic [COLOUR_W-1:0] in_green,
    input  logic [COLOUR_W-1:0] in_red,
    input  cfg_t                cfg,
    output logic                valid,
    output side_t               side,
    output logic [A_W-1:0]      num_x,
    output logic [D_W-1:0]      den_x,
    output logic [A_W-1:0]      num_y,
    output logic [D_W-1:0]      den_y,
    output logic [A_W-1:0]      num_z,
    output logic [D_W-1:0]      den_z
);

    logic [MAG_W-1:0]   pos_x;
    logic [MAG_W-1:0]   pos_y;
    logic [MAG_W-1:0]   cen_x;
    logic [MAG_W-1:0]   cen_y;
    logic               neg_x_next;
    logic               neg_y_next;

    logic               v1_reg;
    logic [MAG_W-1:0]   mag_x_reg;
    logic [MAG_W-1:0]   mag_y_reg;
    logic [DEPTH_W-1:0] depth_reg;
    side_t              side1_reg;

    logic               v2_reg;
    side_t              side2_reg;
    logic [A_W-1:0]     num_x_reg;
    logic [D_W-1:0]     den_x_reg;
    logic [A_W-1:0]     num_y_reg;
    logic [D_W-1:0]     den_y_reg;
    logic [A_W-1:0]     num_z_reg;
    logic [D_W-1:0]     den_z_reg;

    // Pixel index in Q.8 against the Q.8 principal point
    assign pos_x = MAG_W'({coord_t'(pixel_column), 8'h00});
    assign pos_y = MAG_W'({coord_t'(pixel_row), 8'h00});
    assign cen_x = MAG_W'(cfg.center_x);
    assign cen_y = MAG_W'(cfg.center_y);
    assign neg_x_next = cen_x > pos_x;
    assign neg_y_next = cen_y > pos_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            // drop pixels without a depth measurement
            v1_reg <= accept && (pixel_depth != '0);
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_x_reg       <= neg_x_next ? cen_x - pos_x : pos_x - cen_x;
        mag_y_reg       <= neg_y_next ? cen_y - pos_y : pos_y - cen_y;
        depth_reg       <= pixel_depth;
        side1_reg.neg_x <= neg_x_next;
        side1_reg.neg_y <= neg_y_next;
        side1_reg.blue  <= in_blue;
        side1_reg.green <= in_green;
        side1_reg.red   <= in_red;

        side2_reg <= side1_reg;
        num_x_reg <= A_W'(mag_x_reg) * A_W'(depth_reg);
        num_y_reg <= A_W'(mag_y_reg) * A_W'(depth_reg);
        num_z_reg <= A_W'(depth_reg);
        den_x_reg <= D_W'(cfg.depth_scale) * D_W'(cfg.focal_x);
        den_y_reg <= D_W'(cfg.depth_scale) * D_W'(cfg.focal_y);
        den_z_reg <= D_W'(cfg.depth_scale);
    end

    assign valid = v2_reg;
    assign side  = side2_reg;
    assign num_x = num_x_reg;
    assign den_x = den_x_reg;
    assign num_y = num_y_reg;
    assign den_y = den_y_reg;
    assign num_z = num_z_reg;
    assign den_z = den_z_reg;

endmodule

// ===== src/dpb_div.sv =====
// Pipelined restoring divider: floor(num * 2^FRAC_BITS / den) to Q_W bits,
// one quotient bit per stage, with an overflow flag. Uses dpb_pkg.
module dpb_div import dpb_pkg::*;
(
    input  logic           clk,
    input  logic [A_W-1:0] num,
    input  logic [D_W-1:0] den,
    output logic [Q_W-1:0] quot,
    output logic           ovf
);

    logic [D_W-1:0]   rem_reg  [0:Q_W];
    logic [D_W-1:0]   den_reg  [0:Q_W];
    logic [SHIFT-1:0] low_reg  [0:Q_W];
    logic [Q_W-1:0]   quot_reg [0:Q_W];
    logic             ovf_reg  [0:Q_W];

    logic [CMP_W-1:0] num_hi;
    logic             ovf_next;

    // Quotient needs more than Q_W bits when the top of the numerator reaches den.
    // A zero divisor with a nonzero numerator lands here as well.
    assign num_hi   = CMP_W'(num) >> SHIFT;
    assign ovf_next = (num != '0) && (num_hi >= CMP_W'(den));

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= D_W'(num_hi);
        den_reg[0]  <= den;
        low_reg[0]  <= num[SHIFT-1:0];
        quot_reg[0] <= '0;
        ovf_reg[0]  <= ovf_next;
    end

    for (genvar j = 1; j <= Q_W; j++)
    begin : g_step
        localparam int QBIT = Q_W - j;

        logic         nbit;
        logic [D_W:0] trial;
        logic [D_W:0] diff;
        logic         take;

        // bring down the next numerator bit; bits below FRAC_BITS are zero
        if (QBIT >= FRAC_BITS)
        begin : g_num_bit
            assign nbit = low_reg[j-1][QBIT-FRAC_BITS];
        end
        else
        begin : g_zero_bit
            assign nbit = 1'b0;
        end

        // hold the quotient at zero for a zero divisor, so 0/0 gives 0
        assign trial = {rem_reg[j-1], nbit};
        assign diff  = trial - {1'b0, den_reg[j-1]};
        assign take  = (den_reg[j-1] != '0) && (trial >= {1'b0, den_reg[j-1]});

        always_ff @(posedge clk)
        begin
            rem_reg[j]  <= take ? diff[D_W-1:0] : trial[D_W-1:0];
            den_reg[j]  <= den_reg[j-1];
            low_reg[j]  <= low_reg[j-1];
            quot_reg[j] <= {quot_reg[j-1][Q_W-2:0], take};
            ovf_reg[j]  <= ovf_reg[j-1];
        end
    end

    assign quot = quot_reg[Q_W];
    assign ovf  = ovf_reg[Q_W];

endmodule

// ===== src/depth_pixel_backprojection.sv =====
// Depth pixel back-projection: pixel + depth to a Q16.16 point, colour passed through.
// Accepts one pixel per cycle, busy is always low. The pipeline is the front end
// (2 stages), the 33-stage dividers and the output register. Reset clears all valid
// bits and loads the default intrinsics; results are strobed for one cycle and the
// receiver cannot stall.
module depth_pixel_backprojection import dpb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [PIXEL_W-1:0]  pixel_column,
    input  logic [PIXEL_W-1:0]  pixel_row,
    input  logic [DEPTH_W-1:0]  pixel_depth,
    input  logic [COLOUR_W-1:0] in_blue,
    input  logic [COLOUR_W-1:0] in_green,
    input  logic [COLOUR_W-1:0] in_red,
    output logic                done,
    output logic signed [31:0]  point_x,
    output logic signed [31:0]  point_y,
    output logic [30:0]         point_z,
    output logic [COLOUR_W-1:0] out_blue,
    output logic [COLOUR_W-1:0] out_green,
    output logic [COLOUR_W-1:0] out_red,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    cfg_t             cfg;
    logic             prep_valid;
    side_t            prep_side;
    logic [A_W-1:0]   num_x;
    logic [D_W-1:0]   den_x;
    logic [A_W-1:0]   num_y;
    logic [D_W-1:0]   den_y;
    logic [A_W-1:0]   num_z;
    logic [D_W-1:0]   den_z;
    logic [Q_W-1:0]   quot_x;
    logic [Q_W-1:0]   quot_y;
    logic [Q_W-1:0]   quot_z;
    logic             ovf_x;
    logic             ovf_y;
    logic             ovf_z;

    logic [DIV_LAT-1:0] vld_reg;
    side_t              side_reg [0:DIV_LAT-1];

    logic               done_reg;
    logic [Q_W-1:0]     x_reg;
    logic [Q_W-1:0]     y_reg;
    logic [30:0]        z_reg;
    logic [COLOUR_W-1:0] blue_reg;
    logic [COLOUR_W-1:0] green_reg;
    logic [COLOUR_W-1:0] red_reg;

    logic [Q_W-1:0]     z_sat;

    // Limit the magnitude, then apply the sign of the offset
    function automatic logic [Q_W-1:0] sat_lateral(input logic [Q_W-1:0] q,
                                                   input logic ovf,
                                                   input logic neg);
        logic [Q_W-1:0] cap;
        logic [Q_W-1:0] mag;
        cap = neg ? CAP_NEG : CAP_POS;
        mag = (ovf || (q > cap)) ? cap : q;
        return neg ? (~mag + 1'b1) : mag;
    endfunction

    assign busy = 1'b0;

    dpb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dpb_prep u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (start && !busy),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .pixel_depth  (pixel_depth),
        .in_blue      (in_blue),
        .in_green     (in_green),
        .in_red       (in_red),
        .cfg          (cfg),
        .valid        (prep_valid),
        .side         (prep_side),
        .num_x        (num_x),
        .den_x        (den_x),
        .num_y        (num_y),
        .den_y        (den_y),
        .num_z        (num_z),
        .den_z        (den_z)
    );

    dpb_div u_div_x (
        .clk  (clk),
        .num  (num_x),
        .den  (den_x),
        .quot (quot_x),
        .ovf  (ovf_x)
    );

    dpb_div u_div_y (
        .clk  (clk),
        .num  (num_y),
        .den  (den_y),
        .quot (quot_y),
        .ovf  (ovf_y)
    );

    dpb_div u_div_z (
        .clk  (clk),
        .num  (num_z),
        .den  (den_z),
        .quot (quot_z),
        .ovf  (ovf_z)
    );

    // Carry valid and sideband alongside the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[DIV_LAT-2:0], prep_valid};
            done_reg <= vld_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= prep_side;
        for (int k = 1; k < DIV_LAT; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    assign z_sat = (ovf_z || (quot_z > CAP_POS)) ? CAP_POS : quot_z;

    always_ff @(posedge clk)
    begin
        x_reg     <= sat_lateral(quot_x, ovf_x, side_reg[DIV_LAT-1].neg_x);
        y_reg     <= sat_lateral(quot_y, ovf_y, side_reg[DIV_LAT-1].neg_y);
        z_reg     <= z_sat[30:0];
        blue_reg  <= side_reg[DIV_LAT-1].blue;
        green_reg <= side_reg[DIV_LAT-1].green;
        red_reg   <= side_reg[DIV_LAT-1].red;
    end

    assign done      = done_reg;
    assign point_x   = $signed(x_reg);
    assign point_y   = $signed(y_reg);
    assign point_z   = z_reg;
    assign out_blue  = blue_reg;
    assign out_green = green_reg;
    assign out_red   = red_reg;

endmodule

// ===== dv/tb_depth_pixel_backprojection.sv =====
// Self-checking testbench for depth_pixel_backprojection: drives pixel requests and APB
// register writes, and predicts each Q16.16 point in its own model of the camera maths.
// Depends on dpb_pkg and the block itself; needs no files or arguments.
module tb_depth_pixel_backprojection;
    import dpb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 44;      // pipeline is 36 deep
    localparam int CYCLE_LIMIT   = 300000;
    localparam int PHASE_ITEMS   = 258;
    localparam int RANDOM_PHASES = 6;

    typedef struct {
        logic [Q_W-1:0]      x;
        logic [Q_W-1:0]      y;
        logic [30:0]         z;
        logic [COLOUR_W-1:0] blue;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] red;
    } point_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [PIXEL_W-1:0]  pixel_column = '0;
    logic [PIXEL_W-1:0]  pixel_row = '0;
    logic [DEPTH_W-1:0]  pixel_depth = '0;
    logic [COLOUR_W-1:0] in_blue = '0;
    logic [COLOUR_W-1:0] in_green = '0;
    logic [COLOUR_W-1:0] in_red = '0;
    logic                done;
    logic signed [31:0]  point_x;
    logic signed [31:0]  point_y;
    logic [30:0]         point_z;
    logic [COLOUR_W-1:0] out_blue;
    logic [COLOUR_W-1:0] out_green;
    logic [COLOUR_W-1:0] out_red;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    cfg_t   cam = '{RST_DEPTH_SCALE, RST_FOCAL_X, RST_FOCAL_Y, RST_CENTER_X, RST_CENTER_Y};
    point_t pending_points[$];
    int     mismatches = 0;

    depth_pixel_backprojection dut (.*);

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    // floor(num * 2^FRAC_BITS / den), clamped to cap; a zero divisor saturates unless num is 0
    function automatic logic [Q_W-1:0] ratio_q16(input logic [A_W-1:0] num,
                                                 input logic [D_W-1:0] den,
                                                 input logic [Q_W-1:0] cap);
        logic [A_W+FRAC_BITS-1:0] wide;
        if (den == '0)
            return (num != '0) ? cap : '0;
        wide = {num, {FRAC_BITS{1'b0}}} / (A_W+FRAC_BITS)'(den);
        return (wide > (A_W+FRAC_BITS)'(cap)) ? cap : wide[Q_W-1:0];
    endfunction

    function automatic logic [Q_W-1:0] lateral_q16(input logic [PIXEL_W-1:0] pos,
                                                   input logic [CENTER_W-1:0] center,
                                                   input logic [DEPTH_W-1:0] depth,
                                                   input logic [FOCAL_W-1:0] focal);
        logic [POS_W-1:0]  p;
        logic              neg;
        logic [MAG_W-1:0]  mag;
        logic [A_W-1:0]    num;
        logic [D_W-1:0]    den;
        logic [Q_W-1:0]    v;
        p   = {pos[COORD_BITS-1:0], 8'h00};
        neg = center > p;
        mag = neg ? center - p : p - center;
        num = A_W'(mag) * A_W'(depth);
        den = D_W'(cam.depth_scale) * D_W'(focal);
        v   = ratio_q16(num, den, neg ? CAP_NEG : CAP_POS);
        return neg ? -v : v;
    endfunction

    function automatic point_t project_pixel(input logic [PIXEL_W-1:0] col,
                                             input logic [PIXEL_W-1:0] row,
                                             input logic [DEPTH_W-1:0] depth,
                                             input logic [COLOUR_W-1:0] b,
                                             input logic [COLOUR_W-1:0] g,
                                             input logic [COLOUR_W-1:0] r);
        point_t pt;
        logic [Q_W-1:0] z;
        pt.x = lateral_q16(col, cam.center_x, depth, cam.focal_x);
        pt.y = lateral_q16(row, cam.center_y, depth, cam.focal_y);
        z = ratio_q16(A_W'(depth), D_W'(cam.depth_scale), CAP_POS);
        pt.z = z[30:0];
        pt.blue  = b;
        pt.green = g;
        pt.red   = r;
        return pt;
    endfunction

    function automatic logic [DATA_W-1:0] reg_value(input logic [IDX_W-1:0] idx);
        case (idx)
            REG_DEPTH_SCALE: return DATA_W'(cam.depth_scale);
            REG_FOCAL_X:     return DATA_W'(cam.focal_x);
            REG_FOCAL_Y:     return DATA_W'(cam.focal_y);
            REG_CENTER_X:    return DATA_W'(cam.center_x);
            REG_CENTER_Y:    return DATA_W'(cam.center_y);
            default:         return '0;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        point_t want;
        if (rst_n && $isunknown(done))
        begin
            $display("%0t: done expected 0 or 1 got %b", $time, done);
            mismatches++;
        end
        else if (rst_n && done)
        begin
            if (pending_points.size() == 0)
            begin
                $display("%0t: result expected none got x=%h y=%h z=%h",
                         $time, point_x, point_y, point_z);
                mismatches++;
            end
            else
            begin
                want = pending_points.pop_front();
                check_field("point_x", want.x, point_x);
                check_field("point_y", want.y, point_y);
                check_field("point_z", 32'(want.z), 32'(point_z));
                check_field("out_blue", 32'(want.blue), 32'(out_blue));
                check_field("out_green", 32'(want.green), 32'(out_green));
                check_field("out_red", 32'(want.red), 32'(out_red));
            end
        end
    end

    task automatic send_pixel(input logic [PIXEL_W-1:0] col, input logic [PIXEL_W-1:0] row,
                              input logic [DEPTH_W-1:0] depth,
                              input logic [COLOUR_W-1:0] b, input logic [COLOUR_W-1:0] g,
                              input logic [COLOUR_W-1:0] r);
        start        <= 1'b1;
        pixel_column <= col;
        pixel_row    <= row;
        pixel_depth  <= depth;
        in_blue      <= b;
        in_green     <= g;
        in_red       <= r;
        do @(posedge clk); while (busy);
        if (depth != '0)
            pending_points.insert(pending_points.size(),
                                  project_pixel(col, row, depth, b, g, r));
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Hold off until every point is out, then let the pipe settle with start held low
    task automatic drain_results();
        start <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_DEPTH_SCALE: cam.depth_scale = value[SCALE_W-1:0];
            REG_FOCAL_X:     cam.focal_x = value[FOCAL_W-1:0];
            REG_FOCAL_Y:     cam.focal_y = value[FOCAL_W-1:0];
            REG_CENTER_X:    cam.center_x = value[CENTER_W-1:0];
            REG_CENTER_Y:    cam.center_y = value[CENTER_W-1:0];
            default:         ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_check(input logic [IDX_W-1:0] idx);
        logic [DATA_W-1:0] want;
        want = reg_value(idx);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        check_field("prdata", want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_camera(input logic [DATA_W-1:0] scale, input logic [DATA_W-1:0] fx,
                              input logic [DATA_W-1:0] fy, input logic [DATA_W-1:0] cx,
                              input logic [DATA_W-1:0] cy);
        write_reg(REG_DEPTH_SCALE, scale);
        write_reg(REG_FOCAL_X, fx);
        write_reg(REG_FOCAL_Y, fy);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        for (int i = REG_DEPTH_SCALE; i <= REG_CENTER_Y; i++)
            read_check(IDX_W'(i));
    endtask

    function automatic logic [DATA_W-1:0] pick_focal();
        case ($urandom_range(0, 5))
            0:       return 1;
            1:       return 32'h000F_FFFF;
            2:       return $urandom_range(1, 32'h000F_FFFF);
            default: return $urandom_range(64 * 256, 2000 * 256);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_center();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 32'h000F_FFFF;
            2:       return $urandom_range(0, 32'h000F_FFFF);
            default: return $urandom_range(0, 4095 * 256);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_scale();
        case ($urandom_range(0, 5))
            0:       return 1;
            1:       return 32'h0000_FFFF;
            2:       return $urandom_range(1, 32'h0000_FFFF);
            default: return $urandom_range(100, 10000);
        endcase
    endfunction

    task automatic send_random_pixel();
        logic [DEPTH_W-1:0] depth;
        case ($urandom_range(0, 9))
            0:       depth = '0;
            1:       depth = DEPTH_W'($urandom_range(1, 255));
            2:       depth = DEPTH_W'($urandom_range(32'h0000_F000, 32'h0000_FFFF));
            default: depth = DEPTH_W'($urandom_range(1, 32'h0000_FFFF));
        endcase
        send_pixel(PIXEL_W'($urandom_range(0, 4095)), PIXEL_W'($urandom_range(0, 4095)),
                   depth,
                   COLOUR_W'($urandom_range(0, 255)), COLOUR_W'($urandom_range(0, 255)),
                   COLOUR_W'($urandom_range(0, 255)));
    endtask

    // Bursts of random length, each followed by a gap; some bursts run back to back
    task automatic send_bursts(input int count);
        int burst_left;
        int gap;
        burst_left = 0;
        gap = 0;
        for (int i = 0; i < count; i++)
        begin
            if (burst_left == 0)
            begin
                idle_cycles(gap);
                burst_left = $urandom_range(1, 40);
                case ($urandom_range(0, 7))
                    0, 1:    gap = 0;
                    6:       gap = $urandom_range(5, 40);
                    default: gap = $urandom_range(1, 4);
                endcase
            end
            send_random_pixel();
            burst_left--;
            if ($urandom_range(0, 99) == 0)
                drain_results();
        end
    endtask

    task automatic test_reset_defaults();
        for (int i = REG_DEPTH_SCALE; i <= REG_CENTER_Y; i++)
            read_check(IDX_W'(i));
        send_pixel(12'd0, 12'd0, 16'd0, 8'h11, 8'h22, 8'h33);
        send_pixel(12'd4095, 12'd4095, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(12'd0, 12'd0, 16'd1, 8'h00, 8'h00, 8'h00);
        idle_cycles(3);
        // straddle the principal point on both axes
        send_pixel(12'd319, 12'd239, 16'd1000, 8'h12, 8'h34, 8'h56);
        send_pixel(12'd320, 12'd240, 16'd1000, 8'h65, 8'h43, 8'h21);
        send_pixel(12'd4095, 12'd0, 16'd0, 8'hAA, 8'h55, 8'hAA);
        send_pixel(12'd0, 12'd4095, 16'hFFFF, 8'hA5, 8'h5A, 8'hC3);
        drain_results();
    endtask

    task automatic test_saturation();
        set_camera(1, 1, 1, 0, 0);
        send_pixel(12'd0, 12'd0, 16'hFFFF, 8'h01, 8'h02, 8'h04);
        send_pixel(12'd1, 12'd1, 16'd1, 8'h08, 8'h10, 8'h20);
        send_pixel(12'd4095, 12'd4095, 16'hFFFF, 8'h40, 8'h80, 8'hFE);
        send_pixel(12'd0, 12'd0, 16'h7FFF, 8'hFD, 8'hFB, 8'hF7);
        drain_results();
        set_camera(1, 1, 1, 32'h000F_FFFF, 32'h000F_FFFF);
        send_pixel(12'd0, 12'd0, 16'd1, 8'hEF, 8'hDF, 8'hBF);
        send_pixel(12'd4095, 12'd4095, 16'hFFFF, 8'h7F, 8'h00, 8'hFF);
        drain_results();
        set_camera(32'h0000_FFFF, 32'h000F_FFFF, 32'h000F_FFFF, 32'h0008_0000, 32'h0000_0000);
        send_pixel(12'd0, 12'd4095, 16'hFFFF, 8'h3C, 8'hC3, 8'h99);
        send_pixel(12'd4095, 12'd0, 16'd1, 8'h66, 8'h99, 8'h3C);
        drain_results();
    endtask

    task automatic test_zero_divisor();
        set_camera(0, 0, 0, 320 * 256, 0);
        // zero numerator gives zero, anything else saturates with its sign
        send_pixel(12'd320, 12'd0, 16'd500, 8'h01, 8'h23, 8'h45);
        send_pixel(12'd0, 12'd5, 16'd7, 8'h67, 8'h89, 8'hAB);
        drain_results();
    endtask

    task automatic test_unmapped_writes();
        set_camera(DATA_W'(RST_DEPTH_SCALE), DATA_W'(RST_FOCAL_X), DATA_W'(RST_FOCAL_Y),
                   DATA_W'(RST_CENTER_X), DATA_W'(RST_CENTER_Y));
        for (int i = REG_CENTER_Y + 1; i < (1 << IDX_W); i++)
            write_reg(IDX_W'(i), 32'hFFFF_FFFF);
        for (int i = REG_DEPTH_SCALE; i <= REG_CENTER_Y; i++)
            read_check(IDX_W'(i));
        send_pixel(12'd100, 12'd400, 16'd2500, 8'hCD, 8'hEF, 8'h01);
        send_pixel(12'd600, 12'd50, 16'd800, 8'h10, 8'h32, 8'h54);
        drain_results();
    endtask

    task automatic test_random_cameras();
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            // junk above each register's width must be dropped
            set_camera(pick_scale() | ($urandom() << SCALE_W),
                       pick_focal() | ($urandom() << FOCAL_W),
                       pick_focal() | ($urandom() << FOCAL_W),
                       pick_center() | ($urandom() << CENTER_W),
                       pick_center() | ($urandom() << CENTER_W));
            send_bursts(PHASE_ITEMS);
            drain_results();
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_saturation();
        test_zero_divisor();
        test_unmapped_writes();
        test_random_cameras();
        drain_results();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== depth_pixel_backprojection.f =====
src/dpb_pkg.sv
src/dpb_cfg.sv
src/dpb_prep.sv
src/dpb_div.sv
src/depth_pixel_backprojection.sv
dv/tb_depth_pixel_backprojection.sv
